// File: rtl/core/bounded_list_deque_with_search_core_defines.svh
// ----------------------------------------------------------------------------
// Deque core assertion macros
// Shared immediate-style concurrent checks, clocked on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_DEQUE_WITH_SEARCH_CORE_DEFINES_SVH
`define BOUNDED_LIST_DEQUE_WITH_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication.
`define BLDQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BLDQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/bldq_pkg.sv
// ----------------------------------------------------------------------------
// bldq_pkg
// Types and codes shared by the deque core and its storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package bldq_pkg;

   localparam int DATA_WIDTH    = 32;
   localparam int DEPTH_DEFAULT = 16;

   // operation codes
   localparam logic [2:0] MODE_INS_FRONT = 3'd0;
   localparam logic [2:0] MODE_INS_END   = 3'd1;
   localparam logic [2:0] MODE_REM_FRONT = 3'd2;
   localparam logic [2:0] MODE_REM_END   = 3'd3;
   localparam logic [2:0] MODE_REM_MATCH = 3'd4;
   localparam logic [2:0] MODE_SEARCH    = 3'd5;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_PREV,
      CELL_FROM_NEXT
   } cell_op_type;

   typedef struct packed {
      logic        cmp_en;  // capture compare result this cycle
      logic        live;    // cell lies below the entry count
      cell_op_type op;
   } cell_ctl_type;

endpackage

`default_nettype wire

// File: rtl/core/bldq_cell.sv
// ----------------------------------------------------------------------------
// bldq_cell
// One list slot: holds an entry, compares it with the broadcast value and
// shifts towards either neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module bldq_cell (
   input  wire                                   clock,
   input  wire  bldq_pkg::cell_ctl_type          ctl,
   input  wire  [bldq_pkg::DATA_WIDTH-1:0]       value_in,
   input  wire  [bldq_pkg::DATA_WIDTH-1:0]       prev_entry,
   input  wire  [bldq_pkg::DATA_WIDTH-1:0]       next_entry,
   output logic [bldq_pkg::DATA_WIDTH-1:0]       entry_out,
   output logic                                  match_out
);
   import bldq_pkg::*;

   logic [DATA_WIDTH-1:0] entry_ff, entry_in;
   logic                  match_ff, match_in;

   always_comb begin
      unique case (ctl.op)
         CELL_LOAD:      entry_in = value_in;
         CELL_FROM_PREV: entry_in = prev_entry;
         CELL_FROM_NEXT: entry_in = next_entry;
         default:        entry_in = entry_ff;
      endcase
      match_in = ctl.cmp_en ? (ctl.live && (entry_ff == value_in)) : match_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry_out = entry_ff;
   assign match_out = match_ff;

endmodule

`default_nettype wire

// File: rtl/core/bounded_list_deque_with_search_core.sv
// ----------------------------------------------------------------------------
// bounded_list_deque_with_search_core
// Bounded double-ended list of signed words with remove-by-value and search.
// ----------------------------------------------------------------------------
// Usage:
//  - Request: drive req_mode/req_value with start high; the transaction is
//    taken on the edge where start is high and busy is low.
//  - Response: rsp_valid pulses for one cycle with rsp_status,
//    rsp_removed_value and rsp_entry_total. The receiver cannot stall; a
//    response is simply presented once.
//  - Sequence: after acceptance, the match state broadcasts the value and
//    every cell latches its own compare; the apply state resolves the first
//    match with one DEPTH-wide subtract and drives the shift; the response
//    register then shows the result.
//  - Requests do not overlap: busy stays high through the match and apply
//    states. A new request may be taken in the cycle the previous response
//    is on the ports.
//  - Reset (synchronous, active high): list empty, no response pending.
//    Cell contents are not cleared; slots at or beyond the count are never
//    observed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_list_deque_with_search_core_defines.svh"

module bounded_list_deque_with_search_core #(
   parameter int DEPTH = bldq_pkg::DEPTH_DEFAULT,
   localparam int CountWidth = $clog2(DEPTH + 1)
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   output logic                                  busy,
   input  wire  [2:0]                            req_mode,
   input  wire  signed [bldq_pkg::DATA_WIDTH-1:0] req_value,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_status,
   output logic signed [bldq_pkg::DATA_WIDTH-1:0] rsp_removed_value,
   output logic [CountWidth-1:0]                 rsp_entry_total
);
   import bldq_pkg::*;

   localparam int IdxWidth = $clog2(DEPTH);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(DEPTH);

   typedef enum logic [1:0] {S_IDLE, S_MATCH, S_APPLY} state_type;

   state_type             state_ff, state_in;
   logic [2:0]            mode_ff, mode_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [DATA_WIDTH-1:0] rsp_removed_ff, rsp_removed_in;

   cell_ctl_type          ctl [DEPTH];
   logic [DATA_WIDTH-1:0] entries_w [DEPTH];
   logic [DEPTH-1:0]      match_w;

   // first-match resolution: tail mask covers the first hit and all after it
   logic [DEPTH-1:0]      match_low;
   logic [DEPTH-1:0]      tail_mask;
   logic                  found;
   logic                  full;
   logic                  empty;
   logic [CountWidth-1:0] count_m1;
   logic                  accept;

   assign accept    = start && (state_ff == S_IDLE);
   assign match_low = match_w ^ (match_w - {{(DEPTH-1){1'b0}}, 1'b1});
   assign tail_mask = ~(match_low >> 1);
   assign found     = |match_w;
   assign full      = (count_ff == CountFull);
   assign empty     = (count_ff == '0);
   assign count_m1  = count_ff - {{(CountWidth-1){1'b0}}, 1'b1};

   // ---------------------------------------------------------------- cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_w, next_w;
      if (g == 0) begin : g_first
         assign prev_w = '0;
      end else begin : g_mid_prev
         assign prev_w = entries_w[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign next_w = '0;
      end else begin : g_mid_next
         assign next_w = entries_w[g+1];
      end

      bldq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl[g]),
         .value_in   (value_ff),
         .prev_entry (prev_w),
         .next_entry (next_w),
         .entry_out  (entries_w[g]),
         .match_out  (match_w[g])
      );
   end

   // ------------------------------------------------------- control / apply
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      value_in       = value_ff;
      count_in       = count_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;

      for (int i = 0; i < DEPTH; i++) begin
         ctl[i].cmp_en = (state_ff == S_MATCH);
         ctl[i].live   = (count_ff > CountWidth'(i));
         ctl[i].op     = CELL_HOLD;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in  = req_mode;
               value_in = req_value;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            state_in       = S_IDLE;
            rsp_valid_in   = 1'b1;
            rsp_status_in  = STATUS_OK;
            rsp_removed_in = '0;
            unique case (mode_ff)
               MODE_INS_FRONT: begin
                  if (full) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     for (int i = 0; i < DEPTH; i++) begin
                        ctl[i].op = (i == 0) ? CELL_LOAD : CELL_FROM_PREV;
                     end
                     count_in = count_ff + 1'b1;
                  end
               end
               MODE_INS_END: begin
                  if (full) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     for (int i = 0; i < DEPTH; i++) begin
                        if (count_ff == CountWidth'(i)) begin
                           ctl[i].op = CELL_LOAD;
                        end
                     end
                     count_in = count_ff + 1'b1;
                  end
               end
               MODE_REM_FRONT: begin
                  if (empty) begin
                     rsp_status_in = STATUS_EMPTY;
                  end else begin
                     for (int i = 0; i < DEPTH; i++) begin
                        ctl[i].op = CELL_FROM_NEXT;
                     end
                     rsp_removed_in = entries_w[0];
                     count_in       = count_m1;
                  end
               end
               MODE_REM_END: begin
                  if (empty) begin
                     rsp_status_in = STATUS_EMPTY;
                  end else begin
                     rsp_removed_in = entries_w[count_m1[IdxWidth-1:0]];
                     count_in       = count_m1;
                  end
               end
               MODE_REM_MATCH: begin
                  if (empty) begin
                     rsp_status_in = STATUS_EMPTY;
                  end else if (!found) begin
                     rsp_status_in = STATUS_NOTFOUND;
                  end else begin
                     for (int i = 0; i < DEPTH; i++) begin
                        if (tail_mask[i]) begin
                           ctl[i].op = CELL_FROM_NEXT;
                        end
                     end
                     // the matched entry equals the search value
                     rsp_removed_in = value_ff;
                     count_in       = count_m1;
                  end
               end
               MODE_SEARCH: begin
                  if (!found) begin
                     rsp_status_in = STATUS_NOTFOUND;
                  end
               end
               default: begin
                  // unused codes: no change, plain ok
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff        <= mode_in;
      value_ff       <= value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_entry_total   = count_ff;

   // ------------------------------------------------------------ assertions
   `BLDQ_ASSERT_NOW(a_rsp_when_idle, rsp_valid_ff, state_ff == S_IDLE, "response while busy")
   `BLDQ_ASSERT_NEXT(a_accept_busy, accept, state_ff == S_MATCH, "accept did not start match")
   `BLDQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CountFull, "entry count beyond depth")
   `BLDQ_ASSERT_NOW(a_full_status, rsp_valid_ff && (rsp_status_ff == STATUS_FULL), count_ff == CountFull, "full reported below depth")

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded deque core with remove-by-value and
// search. A short directed table covers the empty, full and no-match cases,
// then random traffic in fill and drain bursts is checked against a queue
// model of the list held in the bench.
// ----------------------------------------------------------------------------

module tb_top;

   import bldq_pkg::*;

   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int TOTAL_W     = $clog2(DEPTH + 1);
   localparam int PHASE_ITEMS = 317;      // random transactions per idling phase
   localparam int BURST_LEN   = 48;       // fill/drain bias flips this often
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 10;       // margin to watch for stray responses
   localparam int DIR_ROWS    = 29;

   // one response of the core
   typedef struct {
      status_type         status;
      logic [31:0]        removed;
      logic [TOTAL_W-1:0] total;
   } deque_result_type;

   // directed stimulus row; typed rows carry the response to expect
   typedef struct {
      logic [2:0]       mode;
      logic [31:0]      value;
      bit               typed;
      deque_result_type exp;
   } dir_row_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [2:0]                req_mode;
   logic signed [31:0]        req_value;
   logic                      rsp_valid;
   logic [1:0]                rsp_status;
   logic signed [31:0]        rsp_removed_value;
   logic [TOTAL_W-1:0]        rsp_entry_total;

   // model of the list, entry 0 at the front
   logic [31:0]      held_values[$];
   // responses owed by the core, oldest first
   deque_result_type pending_results[$];

   deque_result_type predicted;
   deque_result_type oldest;
   deque_result_type no_exp;
   bit               drive_typed;
   deque_result_type drive_exp;
   int               accepted_total;
   int               error_count;
   int               cycle_count;

   bounded_list_deque_with_search_core #(
      .DEPTH(DEPTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_entry_total   (rsp_entry_total)
   );

   // 2 ns clock
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Directed table. Empty-list, ignored-mode and full-list rows have their
   // response typed in; the rest are left to the model. The fill sequence
   // alternates ends and repeats two extremes so that first-match removal
   // has duplicates to choose between.
   dir_row_type dir_tab [DIR_ROWS] = '{
      '{MODE_REM_FRONT, 32'h0000_0000, 1'b1, '{STATUS_EMPTY,    32'h0, 5'd0}},
      '{MODE_REM_END,   32'h0000_0000, 1'b1, '{STATUS_EMPTY,    32'h0, 5'd0}},
      '{MODE_REM_MATCH, 32'h7FFF_FFFF, 1'b1, '{STATUS_EMPTY,    32'h0, 5'd0}},
      '{MODE_SEARCH,    32'h0000_0000, 1'b1, '{STATUS_NOTFOUND, 32'h0, 5'd0}},
      '{3'd6,           32'hFFFF_FFFF, 1'b1, '{STATUS_OK,       32'h0, 5'd0}},
      '{3'd7,           32'h8000_0000, 1'b1, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_INS_FRONT, 32'h7FFF_FFFF, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_INS_END,   32'h8000_0000, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_INS_FRONT, 32'h0000_0000, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_INS_END,   32'hFFFF_FFFF, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_INS_FRONT, 32'h0000_0001, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_INS_END,   32'h5555_5555, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_INS_FRONT, 32'hAAAA_AAAA, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_INS_END,   32'h7FFF_FFFF, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_INS_FRONT, 32'h0000_0007, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_INS_END,   32'hFFFF_FFF9, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_INS_FRONT, 32'h1234_5678, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_INS_END,   32'h8000_0000, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_INS_FRONT, 32'h0000_0064, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_INS_END,   32'hFFFF_FF9C, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_INS_FRONT, 32'h0F0F_0F0F, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_INS_END,   32'hF0F0_F0F0, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_INS_FRONT, 32'h0000_0002, 1'b1, '{STATUS_FULL,     32'h0, 5'd16}},
      '{MODE_INS_END,   32'h0000_0002, 1'b1, '{STATUS_FULL,     32'h0, 5'd16}},
      '{MODE_SEARCH,    32'h7FFF_FFFF, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_REM_MATCH, 32'h0000_0002, 1'b1, '{STATUS_NOTFOUND, 32'h0, 5'd16}},
      '{MODE_REM_MATCH, 32'h7FFF_FFFF, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_REM_FRONT, 32'h0000_0000, 1'b0, '{STATUS_OK,       32'h0, 5'd0}},
      '{MODE_REM_END,   32'h0000_0000, 1'b0, '{STATUS_OK,       32'h0, 5'd0}}
   };

   // Applies one operation to the list model and returns the response.
   function automatic deque_result_type apply_deque_op(logic [2:0] op, logic [31:0] val);
      deque_result_type r;
      int               hit;
      r.status  = STATUS_OK;
      r.removed = '0;
      hit       = -1;
      case (op)
         MODE_INS_FRONT, MODE_INS_END: begin
            if (held_values.size() >= DEPTH) begin
               r.status = STATUS_FULL;
            end else if (op == MODE_INS_FRONT) begin
               held_values.push_front(val);
            end else begin
               held_values.push_back(val);
            end
         end
         MODE_REM_FRONT, MODE_REM_END: begin
            if (held_values.size() == 0) begin
               r.status = STATUS_EMPTY;
            end else if (op == MODE_REM_FRONT) begin
               r.removed = held_values.pop_front();
            end else begin
               r.removed = held_values.pop_back();
            end
         end
         MODE_REM_MATCH, MODE_SEARCH: begin
            // first equal entry from the front, exact bit pattern
            for (int i = 0; i < held_values.size(); i++) begin
               if (hit < 0 && held_values[i] == val) hit = i;
            end
            if (op == MODE_REM_MATCH && held_values.size() == 0) begin
               r.status = STATUS_EMPTY;
            end else if (hit < 0) begin
               r.status = STATUS_NOTFOUND;
            end else if (op == MODE_REM_MATCH) begin
               r.removed = held_values[hit];
               held_values.delete(hit);
            end
         end
         default: ;  // modes six and seven do nothing
      endcase
      r.total = TOTAL_W'(held_values.size());
      return r;
   endfunction

   // Values for random traffic: often one already held, so that searches and
   // removals by value hit; otherwise an extreme, the value 5 or a fully random word.
   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 40 && held_values.size() > 0)
         return held_values[$urandom_range(held_values.size() - 1)];
      if (r < 60) begin
         case ($urandom_range(4))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return 32'h0000_0005;
         endcase
      end
      return $urandom;
   endfunction

   // Fill bursts push the list to full, drain bursts back to empty.
   function automatic logic [2:0] pick_mode(bit fill);
      int r;
      r = $urandom_range(99);
      if (r >= 97) return 3'($urandom_range(7, 6));
      if (fill) begin
         if (r < 35) return MODE_INS_FRONT;
         if (r < 70) return MODE_INS_END;
         if (r < 76) return MODE_REM_FRONT;
         if (r < 81) return MODE_REM_END;
         if (r < 89) return MODE_REM_MATCH;
         return MODE_SEARCH;
      end
      if (r < 8)  return MODE_INS_FRONT;
      if (r < 16) return MODE_INS_END;
      if (r < 41) return MODE_REM_FRONT;
      if (r < 65) return MODE_REM_END;
      if (r < 85) return MODE_REM_MATCH;
      return MODE_SEARCH;
   endfunction

   // Presents one transaction, called at a falling edge and returning at the
   // falling edge after it was taken. Idle cycles go in front of it; with no
   // idling start stays high from one transaction to the next.
   task automatic send_item(input logic [2:0] op, input logic [31:0] val, input bit typed,
                            input deque_result_type exp, input int idle_pct);
      int seen;
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start       = 1'b1;
      req_mode    = op;
      req_value   = val;
      drive_typed = typed;
      drive_exp   = exp;
      seen        = accepted_total;
      do @(negedge clock); while (accepted_total == seen);
   endtask

   // Monitor: responses are checked before the transaction taken at the same
   // edge is predicted, since a response always belongs to an earlier one.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $display("%0t: response with none expected: status %0d removed %h total %0d",
                        $time, rsp_status, rsp_removed_value, rsp_entry_total);
               error_count++;
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_status !== oldest.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, oldest.status, rsp_status);
                  error_count++;
               end
               if (rsp_removed_value !== oldest.removed) begin
                  $display("%0t: removed value expected %h actual %h",
                           $time, oldest.removed, rsp_removed_value);
                  error_count++;
               end
               if (rsp_entry_total !== oldest.total) begin
                  $display("%0t: entry total expected %0d actual %0d",
                           $time, oldest.total, rsp_entry_total);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            // the model always advances; typed rows override its answer
            predicted = apply_deque_op(req_mode, req_value);
            if (drive_typed) pending_results.push_back(drive_exp);
            else pending_results.push_back(predicted);
            accepted_total++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL bounded_list_deque_with_search_core");
         $finish;
      end
   end

   initial begin
      bit fill;
      int idle_pct;
      reset          = 1'b1;
      start          = 1'b0;
      req_mode       = MODE_INS_FRONT;
      req_value      = '0;
      drive_typed    = 1'b0;
      no_exp         = '{STATUS_OK, 32'h0, '0};
      drive_exp      = no_exp;
      accepted_total = 0;
      error_count    = 0;
      cycle_count    = 0;
      fill           = 1'b1;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, light sender idling
      for (int n = 0; n < DIR_ROWS; n++) begin
         send_item(dir_tab[n].mode, dir_tab[n].value, dir_tab[n].typed,
                   dir_tab[n].exp, 16);
      end

      // random part: sender idles 16 %, then 88 %, then never
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 16 : (ph == 1) ? 88 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % BURST_LEN == 0) fill = !fill;
            send_item(pick_mode(fill), pick_value(), 1'b0, no_exp, idle_pct);
         end
      end
      start = 1'b0;

      // let every owed response arrive, then watch for strays
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      if (error_count == 0) begin
         $display("PASS bounded_list_deque_with_search_core");
      end else begin
         $display("FAIL bounded_list_deque_with_search_core");
      end
      $finish;
   end

endmodule
